>>> rtl/tws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_pkg
// Types and constants shared by the wheel synchronization controller and its
// shared arithmetic unit.
// ----------------------------------------------------------------------------
package tws_pkg;

  typedef enum logic [0:0] {
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_T_MUL1,
    S_T_MUL2,
    S_T_DIV,
    S_L_MUL,
    S_L_DIV,
    S_F_SEL,
    S_F_MUL,
    S_F_DIV,
    S_AVG,
    S_P_SEL,
    S_SHARE,
    S_PID_P,
    S_PID_I,
    S_PID_D,
    S_OUT
  } state_t;

  localparam logic [2:0] CFG_DIST  = 3'd0;
  localparam logic [2:0] CFG_SPD_B = 3'd1;
  localparam logic [2:0] CFG_SPD_R = 3'd2;
  localparam logic [2:0] CFG_SPD_L = 3'd3;
  localparam logic [2:0] CFG_GP    = 3'd4;
  localparam logic [2:0] CFG_GI    = 3'd5;
  localparam logic [2:0] CFG_GD    = 3'd6;
  localparam logic [2:0] CFG_TMO   = 3'd7;

  localparam logic [1:0] W_BACK  = 2'd0;
  localparam logic [1:0] W_RIGHT = 2'd1;
  localparam logic [1:0] W_LEFT  = 2'd2;

  localparam logic [15:0] K_CPI       = 16'd4889;
  localparam logic [29:0] K_CPI_RND   = 30'd9999;
  localparam logic [30:0] K_CPI_RECIP = 31'd1759218605;
  localparam int          K_CPI_SHIFT = 44;
  localparam logic [15:0] K_RIGHT_PCT = 16'd95;
  localparam logic [15:0] K_LEFT_Q8   = 16'd25088;
  localparam logic [23:0] K_PCT       = 24'd100;
  localparam logic [22:0] K_PCT_RECIP = 23'd5368710;
  localparam int          K_PCT_SHIFT = 29;
  localparam logic [21:0] K_RND_NEG   = 22'd49;
  localparam logic [21:0] K_RND_POS   = 22'd50;

endpackage

>>> rtl/three_wheel_sync_pid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_wheel_sync_pid
// Three-wheel drive synchronization: per-wheel targets, progress averaging
// and PID drive updates, all computed on one shared serial multiply/divide.
// The divider is DW = FRAC_BITS+24 bits wide. A sample taken while idle, or one
// that ends the move, skips the arithmetic. One beat is worked at a time;
// in_stall drops on the edge that presents the result. Synchronous reset idles
// the block and loads the register defaults.
// ----------------------------------------------------------------------------
module three_wheel_sync_pid
  import tws_pkg::*;
#(
  parameter int COUNT_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_addr,
  input  logic [15:0]       cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              kind,
  input  logic [15:0]       back_count,
  input  logic [15:0]       right_enc,
  input  logic [15:0]       left_enc,
  input  logic [15:0]       elapsed_ms,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [7:0] back_drive,
  output logic signed [7:0] right_drive,
  output logic signed [7:0] left_drive,
  output logic              done_res
);

  localparam int          DW      = FRAC_BITS + 24;
  localparam int          FSW     = FRAC_BITS + 18;
  localparam int          AVW     = FRAC_BITS + 17;
  localparam logic [63:0] CMASK   = (64'd1 << COUNT_BITS) - 64'd1;
  localparam logic [15:0] CMASK16 = CMASK[15:0];
  localparam logic [63:0] AVG_MAX = 64'd1 << (FRAC_BITS + 16);

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -64'sh8000_0000) begin
      return -32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [39:0] sat40(input logic signed [40:0] v);
    if (v > 41'sh7F_FFFF_FFFF) begin
      return 40'sh7F_FFFF_FFFF;
    end else if (v < -41'sh80_0000_0000) begin
      return -40'sh80_0000_0000;
    end
    return v[39:0];
  endfunction

  function automatic logic signed [7:0] drv(input logic signed [31:0] lv);
    logic signed [32:0] r;
    r = ($signed({lv[31], lv}) + 33'sd128) >>> 8;
    if (r > 33'sd100) begin
      return 8'sd100;
    end else if (r < -33'sd100) begin
      return -8'sd100;
    end
    return r[7:0];
  endfunction

  logic [9:0]         travel;
  logic signed [7:0]  spd   [3];
  logic [15:0]        gp, gi, gd, tmo;

  state_t             state, state_next;
  logic [1:0]         w;
  logic               moving;
  logic               res_done;
  logic               launched;
  logic [15:0]        tgt   [3];
  logic signed [31:0] lvl   [3];
  logic signed [39:0] esum  [3];
  logic signed [31:0] eprev [3];
  logic [15:0]        cnt   [3];
  logic [63:0]        tmp;
  logic [FSW-1:0]     fsum;
  logic [1:0]         num;
  logic [AVW-1:0]     avg;
  logic signed [31:0] e;
  logic signed [63:0] inc;

  alu_req_t           req;
  logic [63:0]        opa;
  logic [23:0]        opb;
  logic               alu_done;
  logic [63:0]        alu_res;

  logic               in_fire, out_free, w_last, uses_alu, stop_in;
  logic [15:0]        cnt_in [3];
  logic [7:0]         spd_abs;
  logic [63:0]        share_u;
  logic signed [63:0] share_s, cnt_s, err_raw;
  logic signed [31:0] err_sat;
  logic signed [32:0] ediff;
  logic [15:0]        tgt_q;
  logic [29:0]        tgt_x;
  logic [59:0]        tgt_prod;
  logic [15:0]        tgt_quo;
  logic [21:0]        lft_x;
  logic [43:0]        lft_prod;
  logic [14:0]        lft_quo;

  assign cnt_in[0] = back_count & CMASK16;
  assign cnt_in[1] = right_enc & CMASK16;
  assign cnt_in[2] = left_enc & CMASK16;

  assign in_stall = (state != S_IDLE);
  assign in_fire  = in_valid && (state == S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign w_last   = (w == W_LEFT);
  assign stop_in  = !((cnt_in[0] < tgt[0]) || (cnt_in[1] < tgt[1]) ||
                      (cnt_in[2] < tgt[2])) || (elapsed_ms >= tmo);
  assign spd_abs  = spd[w][7] ? 8'(-spd[w]) : spd[w];
  assign share_u  = alu_res >> FRAC_BITS;
  assign share_s  = $signed(share_u);
  assign cnt_s    = $signed({48'd0, cnt[w]});
  assign err_raw  = (w == W_BACK) ? share_s - cnt_s : cnt_s - share_s;
  assign err_sat  = sat32(err_raw);
  assign ediff    = {e[31], e} - {eprev[w][31], eprev[w]};

  // Division by the constants is a multiply by a rounded-up reciprocal.
  assign tgt_x    = tmp[29:0] + K_CPI_RND;
  assign tgt_prod = 60'(tgt_x) * 60'(K_CPI_RECIP);
  assign tgt_quo  = tgt_prod[K_CPI_SHIFT +: 16];
  assign tgt_q    = (64'(tgt_quo) > CMASK) ? CMASK16 : tgt_quo;
  assign lft_x    = tmp[21:0] + (spd[2][7] ? K_RND_NEG : K_RND_POS);
  assign lft_prod = 44'(lft_x) * 44'(K_PCT_RECIP);
  assign lft_quo  = lft_prod[K_PCT_SHIFT +: 15];

  always_ff @(posedge clk) begin
    if (rst) begin
      travel <= '0;
      spd[0] <= '0;
      spd[1] <= '0;
      spd[2] <= '0;
      gp     <= 16'd256;
      gi     <= 16'd256;
      gd     <= 16'd256;
      tmo    <= 16'd2000;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_DIST:  travel <= cfg_wdata[9:0];
        CFG_SPD_B: spd[0] <= cfg_wdata[7:0];
        CFG_SPD_R: spd[1] <= cfg_wdata[7:0];
        CFG_SPD_L: spd[2] <= cfg_wdata[7:0];
        CFG_GP:    gp     <= cfg_wdata;
        CFG_GI:    gi     <= cfg_wdata;
        CFG_GD:    gd     <= cfg_wdata;
        CFG_TMO:   tmo    <= cfg_wdata;
        default:   ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    uses_alu   = 1'b0;
    req.op     = ALU_MUL;
    opa        = '0;
    opb        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (!kind) begin
            state_next = S_T_MUL1;
          end else if (!moving || stop_in) begin
            state_next = S_OUT;
          end else begin
            state_next = S_F_SEL;
          end
        end
      end
      S_T_MUL1: begin
        uses_alu = 1'b1;
        opa      = 64'(travel);
        opb      = 24'(spd_abs);
        if (alu_done) state_next = S_T_MUL2;
      end
      S_T_MUL2: begin
        uses_alu = 1'b1;
        opa      = tmp;
        opb      = 24'(K_CPI);
        if (alu_done) state_next = S_T_DIV;
      end
      S_T_DIV: begin
        state_next = w_last ? S_L_MUL : S_T_MUL1;
      end
      S_L_MUL: begin
        uses_alu = 1'b1;
        opa      = 64'(spd_abs);
        opb      = 24'(K_LEFT_Q8);
        if (alu_done) state_next = S_L_DIV;
      end
      S_L_DIV: begin
        state_next = S_OUT;
      end
      S_F_SEL: begin
        if (tgt[w] == '0) begin
          state_next = w_last ? S_AVG : S_F_SEL;
        end else begin
          state_next = (w == W_RIGHT) ? S_F_MUL : S_F_DIV;
        end
      end
      S_F_MUL: begin
        uses_alu = 1'b1;
        opa      = 64'(cnt[w]);
        opb      = 24'(K_RIGHT_PCT);
        if (alu_done) state_next = S_F_DIV;
      end
      S_F_DIV: begin
        uses_alu = 1'b1;
        req.op   = ALU_DIV;
        opa      = ((w == W_RIGHT) ? tmp : 64'(cnt[w])) << FRAC_BITS;
        opb      = (w == W_RIGHT) ? 24'(24'(tgt[w]) * K_PCT) : 24'(tgt[w]);
        if (alu_done) state_next = w_last ? S_AVG : S_F_SEL;
      end
      S_AVG: begin
        uses_alu = 1'b1;
        req.op   = ALU_DIV;
        opa      = 64'(fsum);
        opb      = 24'(num);
        if (alu_done) state_next = S_P_SEL;
      end
      S_P_SEL: begin
        if (tgt[w] == '0) begin
          state_next = w_last ? S_OUT : S_P_SEL;
        end else begin
          state_next = S_SHARE;
        end
      end
      S_SHARE: begin
        uses_alu = 1'b1;
        opa      = 64'(avg);
        opb      = 24'(tgt[w]);
        if (alu_done) state_next = S_PID_P;
      end
      S_PID_P: begin
        uses_alu = 1'b1;
        opa      = {{32{e[31]}}, e};
        opb      = 24'(gp);
        if (alu_done) state_next = S_PID_I;
      end
      S_PID_I: begin
        uses_alu = 1'b1;
        opa      = {{24{esum[w][39]}}, esum[w]};
        opb      = 24'(gi);
        if (alu_done) state_next = S_PID_D;
      end
      S_PID_D: begin
        uses_alu = 1'b1;
        opa      = {{31{ediff[32]}}, ediff};
        opb      = 24'(gd);
        if (alu_done) state_next = w_last ? S_OUT : S_P_SEL;
      end
      S_OUT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    req.start = uses_alu && !launched;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      moving    <= 1'b0;
      launched  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (req.start) begin
        launched <= 1'b1;
      end else if (alu_done) begin
        launched <= 1'b0;
      end
      if (state == S_IDLE && in_fire) begin
        if (kind && moving && stop_in) moving <= 1'b0;
      end
      if (state == S_L_DIV) moving <= 1'b1;
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          cnt[0]   <= cnt_in[0];
          cnt[1]   <= cnt_in[1];
          cnt[2]   <= cnt_in[2];
          w        <= W_BACK;
          fsum     <= '0;
          num      <= '0;
          res_done <= kind && (!moving || stop_in);
        end
      end
      S_T_MUL1, S_T_MUL2, S_L_MUL, S_F_MUL: begin
        if (alu_done) tmp <= alu_res;
      end
      S_T_DIV: begin
        tgt[w] <= tgt_q;
        if (!w_last) w <= w + 2'd1;
      end
      S_L_DIV: begin
        lvl[0] <= {{16{spd[0][7]}}, spd[0], 8'd0};
        lvl[1] <= {{16{spd[1][7]}}, spd[1], 8'd0};
        lvl[2] <= spd[2][7] ? -$signed(32'(lft_quo)) : $signed(32'(lft_quo));
        for (int i = 0; i < 3; i++) begin
          esum[i]  <= '0;
          eprev[i] <= '0;
        end
        res_done <= 1'b0;
      end
      S_F_SEL, S_P_SEL: begin
        if (tgt[w] == '0 && !w_last) w <= w + 2'd1;
      end
      S_F_DIV: begin
        if (alu_done) begin
          fsum <= fsum + FSW'(alu_res);
          num  <= num + 2'd1;
          if (!w_last) w <= w + 2'd1;
        end
      end
      S_AVG: begin
        if (alu_done) begin
          avg <= (alu_res > AVG_MAX) ? AVW'(AVG_MAX) : AVW'(alu_res);
          w   <= W_BACK;
        end
      end
      S_SHARE: begin
        if (alu_done) begin
          e       <= err_sat;
          esum[w] <= sat40({esum[w][39], esum[w]} + {{9{err_sat[31]}}, err_sat});
        end
      end
      S_PID_P: begin
        if (alu_done) inc <= $signed(alu_res);
      end
      S_PID_I: begin
        if (alu_done) inc <= inc + $signed(alu_res);
      end
      S_PID_D: begin
        if (alu_done) begin
          eprev[w] <= e;
          lvl[w]   <= sat32($signed({{32{lvl[w][31]}}, lvl[w]}) + inc + $signed(alu_res));
          if (!w_last) w <= w + 2'd1;
        end
      end
      S_OUT: begin
        if (out_free) begin
          back_drive  <= res_done ? 8'sd0 : drv(lvl[0]);
          right_drive <= res_done ? 8'sd0 : drv(lvl[1]);
          left_drive  <= res_done ? 8'sd0 : drv(lvl[2]);
          done_res    <= res_done;
        end
      end
      default: ;
    endcase
  end

  tws_alu #(
    .DW(DW)
  ) u_alu (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .opa  (opa),
    .opb  (opb),
    .done (alu_done),
    .res  (alu_res)
  );

endmodule

>>> rtl/tws_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_alu
// Shared serial unit: shift-add multiply of a 64-bit operand by a 16-bit
// unsigned operand, or restoring divide of a DW-bit dividend by a 24-bit
// divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module tws_alu
  import tws_pkg::*;
#(
  parameter int DW = 40
) (
  input  logic        clk,
  input  logic        rst,
  input  alu_req_t    req,
  input  logic [63:0] opa,
  input  logic [23:0] opb,
  output logic        done,
  output logic [63:0] res
);

  localparam int CW = $clog2(DW + 1);

  logic          busy;
  alu_op_t       op_r;
  logic [CW-1:0] cnt;
  logic [63:0]   acc;
  logic [63:0]   mcand;
  logic [15:0]   mplier;
  logic [23:0]   rem;
  logic [23:0]   dvs;
  logic [DW-1:0] quo;
  logic [24:0]   rem_sh;
  logic          ge;

  assign rem_sh = {rem, quo[DW-1]};
  assign ge     = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == CW'(1));
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == CW'(1))) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r   <= req.op;
      cnt    <= (req.op == ALU_MUL) ? CW'(16) : CW'(DW);
      acc    <= '0;
      mcand  <= opa;
      mplier <= opb[15:0];
      rem    <= '0;
      dvs    <= opb;
      quo    <= opa[DW-1:0];
    end else if (busy) begin
      cnt <= cnt - CW'(1);
      if (op_r == ALU_MUL) begin
        if (mplier[0]) begin
          acc <= acc + mcand;
        end
        mcand  <= {mcand[62:0], 1'b0};
        mplier <= {1'b0, mplier[15:1]};
      end else begin
        rem <= ge ? 24'(rem_sh - {1'b0, dvs}) : rem_sh[23:0];
        quo <= {quo[DW-2:0], ge};
      end
    end
  end

  assign res = (op_r == ALU_MUL) ? acc : 64'(quo);

endmodule
